FILE: design/asg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the activity segment gater.
// No dependencies; every other design file imports this package.
package asg_pkg;

    localparam int TRACKS_DEF    = 64;
    localparam int TIME_BITS_DEF = 48;

    // Register reset values in nanoseconds.
    localparam logic [63:0] PRE_GAP_RST      = 64'd20000000;
    localparam logic [63:0] POST_GAP_RST     = 64'd20000000;
    localparam logic [63:0] MIN_DURATION_RST = 64'd100000000;
    localparam logic [63:0] MERGE_GAP_RST    = 64'd1000000000;

    // Result queue depth; a power of two so that the pointers wrap.
    localparam int OUT_DEPTH = 4;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACK_MASK   = 3'd0,
        REG_OBJECT_START = 3'd1,
        REG_OBJECT_END   = 3'd2,
        REG_PRE_GAP      = 3'd3,
        REG_POST_GAP     = 3'd4,
        REG_MIN_DURATION = 3'd5,
        REG_MERGE_GAP    = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_WAIT_FIRST = 2'd0,
        PH_SEEK       = 2'd1,
        PH_OPEN       = 2'd2
    } phase_t;

    // Writes into the result queue from one processed word.
    typedef struct packed {
        logic push0;
        logic push1;
    } asg_push_t;

endpackage

FILE: design/activity_segment_gater_core.sv
`timescale 1ns / 1ps
// Activity segment gater: turns timed per-track activity words into active
// time segments for one masked track group. An accepted word is registered,
// processed in the next cycle and its segments (none, one, or two for the
// final word) are queued in a four-word result queue, from which they are
// offered in order. One word is accepted per cycle while the result queue
// has room for what is in flight; s_tready drops whenever the unread
// results, plus the one or two results that the word in the input register
// may still add, would leave fewer than two free places. Depends on asg_pkg,
// asg_engine and asg_out_fifo.
module activity_segment_gater_core import asg_pkg::*; #(
    parameter int TRACKS    = TRACKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // word time, activity flags, zero padding
    input  logic [((TIME_BITS+TRACKS+7)/8)*8-1:0]       s_tdata,
    input  logic                                        s_tlast,   // final_block
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // segment_start, segment_end, zero padding
    output logic [((2*TIME_BITS+7)/8)*8-1:0]            m_tdata,
    output logic                                        m_tlast,   // last_segment
    input  logic                                        cfg_we,
    input  logic [CFG_IDX_W-1:0]                        cfg_index,
    input  logic [((TRACKS > TIME_BITS) ? TRACKS : TIME_BITS)-1:0] cfg_wdata
);

    localparam int TW     = TIME_BITS;
    localparam int RW     = 2 * TIME_BITS + 1;
    localparam int MDW    = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int CW     = $clog2(OUT_DEPTH + 1);

    logic [TRACKS-1:0] track_mask_reg;
    logic [TW-1:0]     object_start_reg;
    logic [TW-1:0]     object_end_reg;
    logic [TW-1:0]     pre_gap_reg;
    logic [TW-1:0]     post_gap_reg;
    logic [TW-1:0]     min_duration_reg;
    logic [TW-1:0]     merge_gap_reg;

    logic              in_valid_reg;
    logic [TW-1:0]     in_time_reg;
    logic [TRACKS-1:0] in_flags_reg;
    logic              in_final_reg;

    asg_push_t         push;
    logic [RW-1:0]     res0;
    logic [RW-1:0]     res1;
    logic [RW-1:0]     head;
    logic [CW-1:0]     q_count;
    logic [CW:0]       reserve;
    logic              s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_mask_reg   <= '0;
            object_start_reg <= '0;
            object_end_reg   <= '0;
            pre_gap_reg      <= PRE_GAP_RST[TW-1:0];
            post_gap_reg     <= POST_GAP_RST[TW-1:0];
            min_duration_reg <= MIN_DURATION_RST[TW-1:0];
            merge_gap_reg    <= MERGE_GAP_RST[TW-1:0];
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TRACK_MASK:   track_mask_reg   <= cfg_wdata[TRACKS-1:0];
                REG_OBJECT_START: object_start_reg <= cfg_wdata[TW-1:0];
                REG_OBJECT_END:   object_end_reg   <= cfg_wdata[TW-1:0];
                REG_PRE_GAP:      pre_gap_reg      <= cfg_wdata[TW-1:0];
                REG_POST_GAP:     post_gap_reg     <= cfg_wdata[TW-1:0];
                REG_MIN_DURATION: min_duration_reg <= cfg_wdata[TW-1:0];
                REG_MERGE_GAP:    merge_gap_reg    <= cfg_wdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // Room is kept for the word in the input register: two results for a
    // final word, one otherwise.
    assign reserve  = in_valid_reg ? (in_final_reg ? (CW+1)'(2) : (CW+1)'(1)) : '0;
    assign s_tready = ({1'b0, q_count} + reserve) <= (CW+1)'(OUT_DEPTH - 2);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_time_reg  <= s_tdata[TW-1:0];
            in_flags_reg <= s_tdata[TW+TRACKS-1:TW];
            in_final_reg <= s_tlast;
        end
    end

    asg_engine #(
        .TRACKS    (TRACKS),
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (in_valid_reg),
        .in_time      (in_time_reg),
        .in_flags     (in_flags_reg),
        .in_final     (in_final_reg),
        .track_mask   (track_mask_reg),
        .object_start (object_start_reg),
        .object_end   (object_end_reg),
        .pre_gap      (pre_gap_reg),
        .post_gap     (post_gap_reg),
        .min_duration (min_duration_reg),
        .merge_gap    (merge_gap_reg),
        .push         (push),
        .res0         (res0),
        .res1         (res1)
    );

    asg_out_fifo #(
        .W (RW)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .din0       (res0),
        .din1       (res1),
        .pop_ready  (m_tready),
        .dout_valid (m_tvalid),
        .dout       (head),
        .count      (q_count)
    );

    assign m_tdata = MDW'(head[2*TW-1:0]);
    assign m_tlast = head[2*TW];

endmodule

FILE: design/asg_engine.sv
`timescale 1ns / 1ps
// Segment tracking for one registered input word per cycle: open, close,
// merge and flush logic, producing up to two segments. Uses asg_pkg.
module asg_engine import asg_pkg::*; #(
    parameter int TRACKS    = TRACKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [TIME_BITS-1:0]   in_time,
    input  logic [TRACKS-1:0]      in_flags,
    input  logic                   in_final,
    input  logic [TRACKS-1:0]      track_mask,
    input  logic [TIME_BITS-1:0]   object_start,
    input  logic [TIME_BITS-1:0]   object_end,
    input  logic [TIME_BITS-1:0]   pre_gap,
    input  logic [TIME_BITS-1:0]   post_gap,
    input  logic [TIME_BITS-1:0]   min_duration,
    input  logic [TIME_BITS-1:0]   merge_gap,
    output asg_push_t              push,
    output logic [2*TIME_BITS:0]   res0,      // {last, end, start}
    output logic [2*TIME_BITS:0]   res1
);

    localparam int TW = TIME_BITS;

    phase_t        phase_reg, phase_next;
    logic [TW-1:0] open_start_reg, open_start_next;
    logic [TW-1:0] pend_start_reg, pend_start_next;
    logic [TW-1:0] pend_end_reg, pend_end_next;
    logic          have_pend_reg, have_pend_next;
    logic          first_seg_reg, first_seg_next;
    logic          past_end_reg, past_end_next;

    logic          any_active;
    logic          late;
    logic          merge_hit;
    logic [TW:0]   merge_sum;
    logic [TW:0]   start_min;
    logic [TW-1:0] start_min_sat;
    logic [TW-1:0] close_base;
    logic [TW:0]   close_sum;
    logic [TW-1:0] close_sat;
    logic [TW-1:0] close_end;
    logic [TW-1:0] open_val;
    logic [TW-1:0] r0_start;
    logic [TW-1:0] b_start;
    logic [TW-1:0] b_end;
    logic [TW-1:0] r1_start;
    logic [TW-1:0] r1_end;
    logic          b_first;
    logic          fin_add;

    // These all work in parallel off registered state and the input word.
    assign any_active    = |(in_flags & track_mask);
    assign late          = in_time > object_end;
    assign merge_sum     = {1'b0, pend_end_reg} + {1'b0, merge_gap};
    assign merge_hit     = have_pend_reg && (merge_sum > {1'b0, open_start_reg});
    assign start_min     = {1'b0, open_start_reg} + {1'b0, min_duration};
    assign start_min_sat = start_min[TW] ? {TW{1'b1}} : start_min[TW-1:0];
    assign close_base    = any_active ? object_end : in_time;
    assign close_sum     = {1'b0, close_base} + {1'b0, post_gap};
    assign close_sat     = close_sum[TW] ? {TW{1'b1}} : close_sum[TW-1:0];
    // A segment shorter than the minimum (or ending before its start) is
    // stretched to start plus minimum duration.
    assign close_end     = ({1'b0, close_sat} < start_min) ? start_min_sat : close_sat;
    assign open_val      = (in_time >= pre_gap) ? (in_time - pre_gap) : '0;

    // The first segment of a stream never starts before the object.
    assign r0_start = (first_seg_reg && (pend_start_reg < object_start)) ?
                      object_start : pend_start_reg;

    // Final word: the pending segment, if any, is flushed first; the open segment,
    // closed at the object end, is added after it or merged into it.
    assign fin_add  = (phase_reg == PH_OPEN);
    assign b_start  = (fin_add && !merge_hit) ? open_start_reg : pend_start_reg;
    assign b_end    = fin_add ? object_end : pend_end_reg;
    assign b_first  = first_seg_reg && !(fin_add && have_pend_reg && !merge_hit);
    assign r1_start = (b_first && (b_start < object_start)) ? object_start : b_start;
    assign r1_end   = (b_end > object_end) ? object_end : b_end;

    assign res0 = {1'b0, pend_end_reg, r0_start};
    assign res1 = {1'b1, r1_end, r1_start};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT_FIRST;
            have_pend_reg <= 1'b0;
            first_seg_reg <= 1'b1;
            past_end_reg  <= 1'b0;
            open_start_reg <= '0;
            pend_start_reg <= '0;
            pend_end_reg   <= '0;
        end else begin
            phase_reg      <= phase_next;
            have_pend_reg  <= have_pend_next;
            first_seg_reg  <= first_seg_next;
            past_end_reg   <= past_end_next;
            open_start_reg <= open_start_next;
            pend_start_reg <= pend_start_next;
            pend_end_reg   <= pend_end_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        open_start_next = open_start_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        have_pend_next  = have_pend_reg;
        first_seg_next  = first_seg_reg;
        past_end_next   = past_end_reg;
        push            = '0;

        if (in_valid) begin
            if (in_final) begin
                push.push0      = fin_add && have_pend_reg && !merge_hit;
                push.push1      = fin_add || have_pend_reg;
                phase_next      = PH_WAIT_FIRST;
                open_start_next = '0;
                pend_start_next = '0;
                pend_end_next   = '0;
                have_pend_next  = 1'b0;
                first_seg_next  = 1'b1;
                past_end_next   = 1'b0;
            end else if (!past_end_reg || phase_reg == PH_WAIT_FIRST) begin
                unique case (phase_reg)
                    PH_WAIT_FIRST: begin
                        phase_next = PH_SEEK;
                    end
                    PH_SEEK: begin
                        if (in_time > object_start) begin
                            if (late) begin
                                past_end_next = 1'b1;
                            end else if (any_active) begin
                                open_start_next = open_val;
                                phase_next      = PH_OPEN;
                            end
                        end
                    end
                    PH_OPEN: begin
                        if (!any_active || late) begin
                            if (merge_hit) begin
                                pend_end_next = close_end;
                            end else begin
                                if (have_pend_reg) begin
                                    push.push0     = 1'b1;
                                    first_seg_next = 1'b0;
                                end
                                pend_start_next = open_start_reg;
                                pend_end_next   = close_end;
                                have_pend_next  = 1'b1;
                            end
                            phase_next = PH_SEEK;
                            if (late) begin
                                past_end_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_WAIT_FIRST;
                    end
                endcase
            end
        end
    end

endmodule

FILE: design/asg_out_fifo.sv
`timescale 1ns / 1ps
// Small result queue taking up to two words per cycle and giving one while pop_ready is high.
// Uses asg_pkg for the push struct and the depth.
module asg_out_fifo import asg_pkg::*; #(
    parameter int W = 2 * TIME_BITS_DEF + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asg_push_t                     push,
    input  logic [W-1:0]                  din0,
    input  logic [W-1:0]                  din1,
    input  logic                          pop_ready,
    output logic                          dout_valid,
    output logic [W-1:0]                  dout,
    output logic [$clog2(OUT_DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [W-1:0]  mem_reg [OUT_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [PW-1:0] wr_ptr_inc;

    assign pop        = (count_reg != '0) && pop_ready;
    assign wr_ptr_inc = wr_ptr_reg + PW'(1);
    assign dout_valid = (count_reg != '0);
    assign dout       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.push0) + PW'(push.push1);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.push0) + CW'(push.push1) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // A lone second result takes the first free slot.
    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem_reg[wr_ptr_reg] <= din0;
            if (push.push1) begin
                mem_reg[wr_ptr_inc] <= din1;
            end
        end else if (push.push1) begin
            mem_reg[wr_ptr_reg] <= din1;
        end
    end

endmodule

FILE: design/asg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the activity segment gater and the bind that
// attaches them to activity_segment_gater_core. Uses asg_pkg.
module asg_checker import asg_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((2*TIME_BITS+7)/8)*8-1:0]      m_tdata,
    input logic                                  m_tlast
);

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // With nothing in flight the block is ready right after reset.
    a_ready_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> s_tready)
        else $error("input not ready after reset");

    // A result cannot follow reset before an accepted word has passed the
    // input register and been written into the result queue.
    a_no_early_result: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |=> !m_tvalid)
        else $error("result without an accepted word");

endmodule

bind activity_segment_gater_core asg_checker #(
    .TIME_BITS (TIME_BITS)
) u_asg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
